// File: hdl/vlqm_pkg.sv
// Shared types, constants and the sequencer microprogram for the voice link
// quality monitor. Depends on nothing; imported by voice_link_quality_monitor.
`default_nettype none

package vlqm_pkg;

    // event codes on s_cmd
    localparam logic [1:0] CMD_SEQ     = 2'd0;
    localparam logic [1:0] CMD_LATENCY = 2'd1;
    localparam logic [1:0] CMD_HRTT    = 2'd2;
    localparam logic [1:0] CMD_INVALID = 2'd3;

    // sequence wrap window
    localparam logic [7:0] WRAP_NEW_BELOW = 8'd20;
    localparam logic [7:0] WRAP_LAST_FROM = 8'd240;

    // settings tiers
    localparam logic [14:0] TIER_HIGH = 15'd70;
    localparam logic [14:0] TIER_MID  = 15'd60;
    localparam logic [14:0] TIER_LOW  = 15'd25;
    localparam logic [6:0]  IVAL_LONG  = 7'd100;
    localparam logic [6:0]  IVAL_MID   = 7'd60;
    localparam logic [6:0]  IVAL_SHORT = 7'd40;
    localparam logic [16:0] PAD_LOW    = 17'd25;
    localparam logic [16:0] PAD_MIN    = 17'd20;

    localparam int unsigned LOSS_SCALE = 100;
    localparam logic [1:0]  INV_LIMIT  = 2'd2;

    // reciprocal multipliers: ceil(2^k/d), exact for numerators below 2^k
    localparam int unsigned RECIP_3 = 43691;
    localparam int unsigned SHR_3   = 17;
    localparam int unsigned RECIP_5 = 52429;
    localparam int unsigned SHR_5   = 18;
    // same multiplier with one more shift divides by 10, exact below 2^18
    localparam int unsigned SHR_10  = 19;

    localparam int unsigned PC_W = 5;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_DIV_LOSS,
        OP_DIV_STEP,
        OP_SET_LOSS,
        OP_MARK,
        OP_EMIT,
        OP_CLAMP,
        OP_JIT,
        OP_DIV_PING_X,
        OP_SET_PING,
        OP_DIV_TIER,
        OP_SET_TIER,
        OP_DIV_P10,
        OP_SET_D1,
        OP_PICK,
        OP_DIV_PING_H,
        OP_DIV_P5,
        OP_SET_D2,
        OP_INVALID
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_SCAN,
        COND_NOWRAP,
        COND_END
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_CLEAR   = 5'd0;
    localparam logic [PC_W-1:0] PC_CLR_SCN = 5'd1;
    localparam logic [PC_W-1:0] PC_CLR_END = 5'd2;
    localparam logic [PC_W-1:0] PC_SEQ     = 5'd3;
    localparam logic [PC_W-1:0] PC_SCN_INI = 5'd4;
    localparam logic [PC_W-1:0] PC_SCAN    = 5'd5;
    localparam logic [PC_W-1:0] PC_SCN_END = 5'd6;
    localparam logic [PC_W-1:0] PC_LOSS_ST = 5'd7;
    localparam logic [PC_W-1:0] PC_LOSS_DV = 5'd8;
    localparam logic [PC_W-1:0] PC_LOSS_WR = 5'd9;
    localparam logic [PC_W-1:0] PC_MARK    = 5'd10;
    localparam logic [PC_W-1:0] PC_EMIT    = 5'd11;
    localparam logic [PC_W-1:0] PC_LAT     = 5'd12;
    localparam logic [PC_W-1:0] PC_JIT     = 5'd13;
    localparam logic [PC_W-1:0] PC_PX_ST   = 5'd14;
    localparam logic [PC_W-1:0] PC_PX_DV   = 5'd15;
    localparam logic [PC_W-1:0] PC_PX_WR   = 5'd16;
    localparam logic [PC_W-1:0] PC_TR_ST   = 5'd17;
    localparam logic [PC_W-1:0] PC_TR_DV   = 5'd18;
    localparam logic [PC_W-1:0] PC_TR_WR   = 5'd19;
    localparam logic [PC_W-1:0] PC_P10_ST  = 5'd20;
    localparam logic [PC_W-1:0] PC_P10_DV  = 5'd21;
    localparam logic [PC_W-1:0] PC_D1      = 5'd22;
    localparam logic [PC_W-1:0] PC_PICK    = 5'd23;
    localparam logic [PC_W-1:0] PC_HRTT    = 5'd24;
    localparam logic [PC_W-1:0] PC_PH_DV   = 5'd25;
    localparam logic [PC_W-1:0] PC_PH_WR   = 5'd26;
    localparam logic [PC_W-1:0] PC_P5_ST   = 5'd27;
    localparam logic [PC_W-1:0] PC_P5_DV   = 5'd28;
    localparam logic [PC_W-1:0] PC_D2      = 5'd29;
    localparam logic [PC_W-1:0] PC_INV     = 5'd30;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_END, target: PC_CLEAR};
        unique case (pc)
            // map clearing pass after reset
            PC_CLEAR:   w = '{op: OP_SCAN_INIT,  cond: COND_NEXT,   target: PC_CLEAR};
            PC_CLR_SCN: w = '{op: OP_SCAN,       cond: COND_SCAN,   target: PC_CLR_SCN};
            PC_CLR_END: w = '{op: OP_NOP,        cond: COND_END,    target: PC_CLEAR};
            // audio sequence report
            PC_SEQ:     w = '{op: OP_NOP,        cond: COND_NOWRAP, target: PC_MARK};
            PC_SCN_INI: w = '{op: OP_SCAN_INIT,  cond: COND_NEXT,   target: PC_CLEAR};
            PC_SCAN:    w = '{op: OP_SCAN,       cond: COND_SCAN,   target: PC_SCAN};
            PC_SCN_END: w = '{op: OP_NOP,        cond: COND_NEXT,   target: PC_CLEAR};
            PC_LOSS_ST: w = '{op: OP_DIV_LOSS,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_LOSS_DV: w = '{op: OP_DIV_STEP,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_LOSS_WR: w = '{op: OP_SET_LOSS,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_MARK:    w = '{op: OP_MARK,       cond: COND_NEXT,   target: PC_CLEAR};
            PC_EMIT:    w = '{op: OP_EMIT,       cond: COND_END,    target: PC_CLEAR};
            // latency sample
            PC_LAT:     w = '{op: OP_CLAMP,      cond: COND_NEXT,   target: PC_CLEAR};
            PC_JIT:     w = '{op: OP_JIT,        cond: COND_NEXT,   target: PC_CLEAR};
            PC_PX_ST:   w = '{op: OP_DIV_PING_X, cond: COND_NEXT,   target: PC_CLEAR};
            PC_PX_DV:   w = '{op: OP_DIV_STEP,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_PX_WR:   w = '{op: OP_SET_PING,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_TR_ST:   w = '{op: OP_DIV_TIER,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_TR_DV:   w = '{op: OP_DIV_STEP,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_TR_WR:   w = '{op: OP_SET_TIER,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_P10_ST:  w = '{op: OP_DIV_P10,    cond: COND_NEXT,   target: PC_CLEAR};
            PC_P10_DV:  w = '{op: OP_DIV_STEP,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_D1:      w = '{op: OP_SET_D1,     cond: COND_NEXT,   target: PC_CLEAR};
            PC_PICK:    w = '{op: OP_PICK,       cond: COND_JUMP,   target: PC_EMIT};
            // handshake half round trip
            PC_HRTT:    w = '{op: OP_DIV_PING_H, cond: COND_NEXT,   target: PC_CLEAR};
            PC_PH_DV:   w = '{op: OP_DIV_STEP,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_PH_WR:   w = '{op: OP_SET_PING,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_P5_ST:   w = '{op: OP_DIV_P5,     cond: COND_NEXT,   target: PC_CLEAR};
            PC_P5_DV:   w = '{op: OP_DIV_STEP,   cond: COND_NEXT,   target: PC_CLEAR};
            PC_D2:      w = '{op: OP_SET_D2,     cond: COND_JUMP,   target: PC_PICK};
            // invalid session
            PC_INV:     w = '{op: OP_INVALID,    cond: COND_JUMP,   target: PC_EMIT};
            default:    w = '{op: OP_NOP,        cond: COND_END,    target: PC_CLEAR};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/voice_link_quality_monitor.sv
// Accept to result: a sequence report, with a map scan added on a wrap, a latency sample,
// a half round trip or an invalid session runs its microprogram, plus any wait on m_ready.
// One item at a time: s_ready stays low until an item is through. The wrap
// cost is the one-bit-a-cycle map scan; each division is a registered reciprocal multiply.
// Reset (synchronous, aresetn low) clears all estimates, then a clearing pass over the
// received map holds s_ready low. Microprogram from vlqm_pkg.
`default_nettype none

module voice_link_quality_monitor #(
    parameter int unsigned SEQ_SPACE = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [7:0]         s_audio_seq,
    input  logic signed [15:0] s_latency_ms,
    input  logic [14:0]        s_half_rtt_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [6:0]         m_loss_percent,
    output logic [14:0]        m_ping_average,
    output logic [14:0]        m_jitter_average,
    output logic [6:0]         m_capture_interval_ms,
    output logic [16:0]        m_playout_delay_ms,
    output logic               m_settings_update,
    output logic               m_resync_request,
    output logic               m_close_request
);
    import vlqm_pkg::*;

    localparam int unsigned ADDR_W    = $clog2(SEQ_SPACE);
    localparam int unsigned CNT_W     = $clog2(SEQ_SPACE + 1);
    localparam int unsigned PROD_W    = $clog2(LOSS_SCALE * SEQ_SPACE + 1);
    localparam int unsigned NUM_W     = (PROD_W > 18) ? PROD_W : 18;
    localparam int unsigned MOD_W     = (ADDR_W + 1 > 8) ? ADDR_W + 1 : 8;
    localparam int unsigned MOD_STEPS = 255 / SEQ_SPACE;
    // loss divide: ceil(2^k/SEQ_SPACE), exact for every scaled miss count
    localparam int unsigned     LOSS_SHR   = PROD_W + ADDR_W;
    localparam longint unsigned LOSS_RECIP = ((64'd1 << LOSS_SHR) + SEQ_SPACE - 1) / SEQ_SPACE;
    localparam int unsigned     LR_W       = $clog2(LOSS_RECIP + 1);
    localparam int unsigned     RECIP_W    = (LR_W > 16) ? LR_W : 16;
    localparam int unsigned     MUL_W      = NUM_W + RECIP_W;

    // received map
    logic              map_mem [SEQ_SPACE];
    logic              rd_data_reg;
    logic              rd_vld_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;

    // sequencer
    logic            busy_reg;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_next;
    uword_t          uw;
    logic            stall;
    logic            run;
    logic            emit;

    // request fields
    logic [7:0]         seq_reg;
    logic signed [15:0] lat_reg;
    logic [14:0]        half_reg;

    // estimates
    logic [7:0]  last_reg;
    logic [6:0]  loss_reg;
    logic [14:0] prev_reg;
    logic [14:0] ping_reg;
    logic [14:0] jit_reg;
    logic [1:0]  inv_reg;

    // working registers
    logic [14:0]       x_reg;
    logic [14:0]       tier_reg;
    logic [16:0]       delay_reg;
    logic [6:0]        ival_reg;
    logic [16:0]       play_reg;
    logic              upd_reg;
    logic              resync_reg;
    logic              close_reg;
    logic [ADDR_W-1:0] scan_addr_reg;
    logic [CNT_W-1:0]  missing_reg;

    // reciprocal multiplier
    logic [NUM_W-1:0]   num_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic [MUL_W-1:0]   prod_reg;

    logic               wrap;
    logic [ADDR_W-1:0]  seq_idx;
    logic [NUM_W-1:0]   num;
    logic [RECIP_W-1:0] recip;
    logic               div_start;
    logic [14:0]        q3, q5, q10;
    logic [14:0]        prev_eff;
    logic [14:0]        jdiff;
    logic [15:0]        jsum;
    logic [7:0]         loss_sum;
    logic [6:0]         loss_q;

    function automatic logic [ADDR_W-1:0] seq_mod(input logic [7:0] s);
        logic [MOD_W-1:0] v;
        v = MOD_W'(s);
        for (int i = 0; i < MOD_STEPS; i++) begin
            if (v >= MOD_W'(SEQ_SPACE)) begin
                v = v - MOD_W'(SEQ_SPACE);
            end
        end
        return ADDR_W'(v);
    endfunction

    assign s_ready = !busy_reg;
    assign uw      = ucode(pc_reg);
    assign stall   = (uw.op == OP_EMIT) && m_valid && !m_ready;
    assign run     = busy_reg && !stall;
    assign emit    = run && (uw.op == OP_EMIT);
    assign wrap    = (seq_reg < WRAP_NEW_BELOW) && (last_reg >= WRAP_LAST_FROM);
    assign seq_idx = seq_mod(seq_reg);

    always_comb begin
        pc_next   = pc_reg + PC_W'(1);
        busy_next = busy_reg;
        unique case (uw.cond)
            COND_NEXT:   pc_next = pc_reg + PC_W'(1);
            COND_JUMP:   pc_next = uw.target;
            COND_SCAN:   if (scan_addr_reg != ADDR_W'(SEQ_SPACE - 1)) pc_next = uw.target;
            COND_NOWRAP: if (!wrap) pc_next = uw.target;
            COND_END:    busy_next = 1'b0;
            default:     busy_next = 1'b0;
        endcase
    end

    // numerator and reciprocal per start op
    always_comb begin
        num       = '0;
        recip     = RECIP_W'(RECIP_5);
        div_start = 1'b1;
        unique case (uw.op)
            OP_DIV_LOSS: begin
                num   = NUM_W'(missing_reg) * NUM_W'(LOSS_SCALE);
                recip = RECIP_W'(LOSS_RECIP);
            end
            OP_DIV_PING_X: begin
                num = NUM_W'({ping_reg, 2'b00}) + NUM_W'(x_reg);
            end
            OP_DIV_PING_H: begin
                num = NUM_W'({ping_reg, 2'b00}) + NUM_W'(half_reg);
            end
            OP_DIV_TIER: begin
                num   = NUM_W'(jit_reg) + NUM_W'(ping_reg);
                recip = RECIP_W'(RECIP_3);
            end
            OP_DIV_P10: begin
                num = NUM_W'(ping_reg);
            end
            OP_DIV_P5: begin
                num = NUM_W'(ping_reg);
            end
            default: div_start = 1'b0;
        endcase
    end

    always_comb begin
        q3       = 15'(prod_reg >> SHR_3);
        q5       = 15'(prod_reg >> SHR_5);
        q10      = 15'(prod_reg >> SHR_10);
        // first sample: previous takes the sample, so no jitter is added
        prev_eff = (prev_reg == '0) ? x_reg : prev_reg;
        jdiff    = (prev_eff >= x_reg) ? prev_eff - x_reg : x_reg - prev_eff;
        jsum     = {1'b0, jit_reg} + {1'b0, jdiff};
        loss_q   = 7'(prod_reg >> LOSS_SHR);
        loss_sum = {1'b0, loss_q} + {1'b0, loss_reg};
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = scan_addr_reg;
        mem_wdata = 1'b0;
        if (run && uw.op == OP_SCAN) begin
            mem_we = 1'b1;
        end else if (run && uw.op == OP_MARK) begin
            mem_we    = 1'b1;
            mem_waddr = seq_idx;
            mem_wdata = 1'b1;
        end
    end

    // read and clear at the scan address in the same cycle: read returns the old bit
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= map_mem[scan_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b1;
            pc_reg     <= PC_CLEAR;
            rd_vld_reg <= 1'b0;
            m_valid    <= 1'b0;
            last_reg   <= '0;
            loss_reg   <= '0;
            prev_reg   <= '0;
            ping_reg   <= '0;
            jit_reg    <= '0;
            inv_reg    <= '0;
        end else begin
            rd_vld_reg <= run && (uw.op == OP_SCAN);
            if (rd_vld_reg && !rd_data_reg) begin
                missing_reg <= missing_reg + CNT_W'(1);
            end
            if (emit) begin
                m_valid <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end

            if (!busy_reg) begin
                if (s_valid) begin
                    busy_reg   <= 1'b1;
                    seq_reg    <= s_audio_seq;
                    lat_reg    <= s_latency_ms;
                    half_reg   <= s_half_rtt_ms;
                    ival_reg   <= '0;
                    play_reg   <= '0;
                    upd_reg    <= 1'b0;
                    resync_reg <= 1'b0;
                    close_reg  <= 1'b0;
                    unique case (s_cmd)
                        CMD_SEQ:     pc_reg <= PC_SEQ;
                        CMD_LATENCY: pc_reg <= PC_LAT;
                        CMD_HRTT:    pc_reg <= PC_HRTT;
                        CMD_INVALID: pc_reg <= PC_INV;
                        default:     pc_reg <= PC_INV;
                    endcase
                end
            end else if (run) begin
                pc_reg   <= pc_next;
                busy_reg <= busy_next;

                if (div_start) begin
                    num_reg   <= num;
                    recip_reg <= recip;
                end

                unique case (uw.op)
                    OP_SCAN_INIT: begin
                        scan_addr_reg <= '0;
                        missing_reg   <= '0;
                    end
                    OP_SCAN: scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                    OP_DIV_STEP: prod_reg <= MUL_W'(num_reg) * MUL_W'(recip_reg);
                    OP_SET_LOSS: loss_reg <= (loss_reg != '0) ? loss_sum[7:1] : loss_q;
                    OP_MARK:     last_reg <= seq_reg;
                    OP_EMIT: begin
                        m_loss_percent        <= loss_reg;
                        m_ping_average        <= ping_reg;
                        m_jitter_average      <= jit_reg;
                        m_capture_interval_ms <= ival_reg;
                        m_playout_delay_ms    <= play_reg;
                        m_settings_update     <= upd_reg;
                        m_resync_request      <= resync_reg;
                        m_close_request       <= close_reg;
                    end
                    OP_CLAMP: begin
                        // zero or negative latency counts as 1 ms
                        if (lat_reg[15]) begin
                            x_reg      <= 15'd1;
                            resync_reg <= 1'b1;
                        end else if (lat_reg == '0) begin
                            x_reg <= 15'd1;
                        end else begin
                            x_reg <= lat_reg[14:0];
                        end
                    end
                    OP_JIT: begin
                        jit_reg  <= jsum[15:1];
                        prev_reg <= x_reg;
                    end
                    OP_SET_PING: ping_reg <= q5;
                    OP_SET_TIER: tier_reg <= q3;
                    OP_SET_D1: begin
                        delay_reg <= 17'(ping_reg) + 17'(q10) + 17'(jit_reg);
                    end
                    OP_SET_D2: begin
                        delay_reg <= 17'(ping_reg) + 17'(q5);
                        tier_reg  <= half_reg;
                    end
                    OP_PICK: begin
                        upd_reg <= 1'b1;
                        priority if (tier_reg >= TIER_HIGH) begin
                            ival_reg <= IVAL_LONG;
                            play_reg <= delay_reg;
                        end else if (tier_reg >= TIER_MID) begin
                            ival_reg <= IVAL_MID;
                            play_reg <= delay_reg;
                        end else if (tier_reg >= TIER_LOW) begin
                            ival_reg <= IVAL_SHORT;
                            play_reg <= delay_reg + PAD_LOW;
                        end else begin
                            ival_reg <= IVAL_SHORT;
                            play_reg <= delay_reg + PAD_MIN;
                        end
                    end
                    OP_INVALID: begin
                        if (inv_reg >= INV_LIMIT) begin
                            inv_reg   <= '0;
                            ping_reg  <= '0;
                            close_reg <= 1'b1;
                        end else begin
                            inv_reg <= inv_reg + 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // a result appears only from the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(busy_reg && uw.op == OP_EMIT))
        else $error("result raised outside emit step");

    // an accepted request starts the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> busy_reg)
        else $error("request accepted but sequencer idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        loss_reg <= 7'd100)
        else $error("loss percent above 100");

    // the invalid-session count wraps before reaching three
    assert property (@(posedge aclk) disable iff (!aresetn)
        (run && uw.op == OP_INVALID && inv_reg == INV_LIMIT) |=> (inv_reg == '0 && close_reg))
        else $error("invalid-session close missed");

endmodule

`default_nettype wire
